FILE: hw/rtl/rv32_pkg.sv
package rv32_pkg;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ = 2'd1,
		OP_EXEC = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	localparam logic [1:0] ST_CONT = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_BADOP = 2'd2;

	localparam logic [6:0] OPC_OP = 7'h33;
	localparam logic [6:0] OPC_OPIMM = 7'h13;
	localparam logic [6:0] OPC_AUIPC = 7'h17;
	localparam logic [6:0] OPC_LUI = 7'h37;
	localparam logic [6:0] OPC_LOAD = 7'h03;
	localparam logic [6:0] OPC_STORE = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL = 7'h6F;
	localparam logic [6:0] OPC_JALR = 7'h67;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_FENCE = 7'h0F;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_MEM,
		S_WB,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_in;    // latch input item
		logic mem_rd;     // issue byte read at address counter
		logic mem_wr;     // write byte at address counter
		logic fetch;      // reading instruction bytes
		logic decode;     // run alu, set pc and memory address
		logic cnt_clr;
		logic cnt_inc;
		logic commit;     // write register / finalize
		logic restart;
	} cmd_t;

	typedef struct packed {
		op_t op;
		logic is_load;
		logic is_store;
		logic [2:0] nbytes;  // bytes for memory access
		logic [2:0] cnt;
	} status_t;

endpackage

FILE: hw/rtl/rv32_if.sv
interface rv32_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [15:0] byte_address;
	logic [7:0] write_byte;
	modport source (output valid, output op, output byte_address, output write_byte,
		input ready);
	modport sink (input valid, input op, input byte_address, input write_byte,
		output ready);
endinterface

interface rv32_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic char_valid;
	logic [7:0] char_out;
	logic [7:0] read_byte;
	logic [15:0] pc_after;
	modport source (output valid, output status, output char_valid, output char_out,
		output read_byte, output pc_after, input ready);
	modport sink (input valid, input status, input char_valid, input char_out,
		input read_byte, input pc_after, output ready);
endinterface

interface rv32_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rv32_ctrl.sv
module rv32_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input rv32_pkg::status_t stat,
	output rv32_pkg::cmd_t cmd
);

	rv32_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rv32_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// reads are registered, so the fetch and load states stay past their last issued read to capture its byte
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rv32_pkg::S_IDLE: begin
				if (in_valid) state_d = rv32_pkg::S_FETCH;
			end
			rv32_pkg::S_FETCH: begin
				if (stat.op != rv32_pkg::OP_EXEC) state_d = rv32_pkg::S_OUT;
				else if (stat.cnt == 3'd4) state_d = rv32_pkg::S_EXEC;
			end
			// load and store flags are only known once decode has been registered
			rv32_pkg::S_EXEC: state_d = rv32_pkg::S_MEM;
			rv32_pkg::S_MEM: begin
				if (stat.is_store && stat.cnt == stat.nbytes - 3'd1) state_d = rv32_pkg::S_WB;
				else if (stat.is_load && stat.cnt == stat.nbytes) state_d = rv32_pkg::S_WB;
				else if (!stat.is_load && !stat.is_store) state_d = rv32_pkg::S_WB;
			end
			rv32_pkg::S_WB: state_d = rv32_pkg::S_OUT;
			rv32_pkg::S_OUT: begin
				if (out_ready) state_d = rv32_pkg::S_IDLE;
			end
			default: state_d = rv32_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			rv32_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.take_in = in_valid;
				cmd.cnt_clr = 1'b1;
			end
			rv32_pkg::S_FETCH: begin
				unique case (stat.op)
					rv32_pkg::OP_WRITE: cmd.mem_wr = 1'b1;
					rv32_pkg::OP_READ: cmd.mem_rd = 1'b1;
					rv32_pkg::OP_RESTART: cmd.restart = 1'b1;
					default: begin
						cmd.fetch = 1'b1;
						cmd.mem_rd = (stat.cnt < 3'd4);
						cmd.cnt_inc = 1'b1;
					end
				endcase
			end
			rv32_pkg::S_EXEC: begin
				cmd.decode = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			rv32_pkg::S_MEM: begin
				cmd.cnt_inc = 1'b1;
				cmd.mem_wr = stat.is_store;
				cmd.mem_rd = stat.is_load && (stat.cnt < stat.nbytes);
			end
			rv32_pkg::S_WB: cmd.commit = 1'b1;
			rv32_pkg::S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/rv32_dp.sv
module rv32_dp #(
	parameter int MEM_BYTES = 65536
) (
	input logic clk,
	input logic arst_n,
	input rv32_pkg::cmd_t cmd,
	output rv32_pkg::status_t stat,
	input logic [1:0] in_op,
	input logic [15:0] in_addr,
	input logic [7:0] in_byte,
	input logic [15:0] entry_q,
	output logic [1:0] status,
	output logic char_valid,
	output logic [7:0] char_out,
	output logic [7:0] read_byte,
	output logic [15:0] pc_after
);

	localparam int AW = $clog2(MEM_BYTES);

	logic [7:0] mem [MEM_BYTES];
	logic [31:0] rf_q [32];
	logic [AW-1:0] pc_q;
	logic [1:0] op_q;
	logic [AW-1:0] baddr_q;
	logic [7:0] wbyte_q;
	logic [31:0] inst_q;
	logic [7:0] rdata_q;
	logic [2:0] cnt_q;
	logic [2:0] rcnt_q;
	logic [AW-1:0] maddr_q;
	logic [31:0] b_q, res_q, ldata_q;
	logic wen_q, isld_q, isst_q;
	logic [2:0] f3_q;
	logic [4:0] rd_q;
	logic [1:0] status_q;
	logic cv_q;
	logic [7:0] co_q, rb_q;

	// decode fields of the fetched word
	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [4:0] rs1, rs2;
	logic [31:0] ra, rb, imm_i, imm_s, imm_b, imm_u, imm_j;
	assign opc = inst_q[6:0];
	assign f3 = inst_q[14:12];
	assign f7 = inst_q[31:25];
	assign rs1 = inst_q[19:15];
	assign rs2 = inst_q[24:20];
	assign ra = rf_q[rs1];
	assign rb = rf_q[rs2];
	assign imm_i = {{20{inst_q[31]}}, inst_q[31:20]};
	assign imm_s = {{20{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
	assign imm_b = {{19{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25], inst_q[11:8], 1'b0};
	assign imm_u = {inst_q[31:12], 12'd0};
	assign imm_j = {{11{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21], 1'b0};

	logic [31:0] pc32, next32, opb;
	assign pc32 = 32'(pc_q);
	assign next32 = 32'(AW'(pc_q + AW'(4)));
	assign opb = (opc == rv32_pkg::OPC_OP) ? rb : imm_i;

	logic lt_s, lt_u;
	assign lt_s = $signed(ra) < $signed(opb);
	assign lt_u = ra < opb;

	logic [31:0] alu;
	logic alu_ok;
	always_comb begin
		alu = '0;
		alu_ok = 1'b1;
		unique case (f3)
			3'd0: alu = (opc == rv32_pkg::OPC_OP && f7 == 7'h20) ? ra - opb : ra + opb;
			3'd1: begin
				alu = ra << opb[4:0];
				if (opc == rv32_pkg::OPC_OPIMM && f7 != 7'h00) alu_ok = 1'b0;
			end
			3'd2: alu = {31'd0, lt_s};
			3'd3: alu = {31'd0, lt_u};
			3'd4: alu = ra ^ opb;
			3'd5: begin
				if (f7 == 7'h20) alu = 32'($signed(ra) >>> opb[4:0]);
				else alu = ra >> opb[4:0];
				if (opc == rv32_pkg::OPC_OPIMM && f7 != 7'h00 && f7 != 7'h20) alu_ok = 1'b0;
			end
			3'd6: alu = ra | opb;
			default: alu = ra & opb;
		endcase
	end

	logic take;
	always_comb begin
		unique case (f3)
			3'd0: take = (ra == rb);
			3'd1: take = (ra != rb);
			3'd4: take = $signed(ra) < $signed(rb);
			3'd5: take = !($signed(ra) < $signed(rb));
			3'd6: take = ra < rb;
			3'd7: take = ra >= rb;
			default: take = 1'b0;
		endcase
	end

	logic [31:0] ld_val;
	always_comb begin
		unique case (f3_q)
			3'd0: ld_val = {{24{ldata_q[7]}}, ldata_q[7:0]};
			3'd1: ld_val = {{16{ldata_q[15]}}, ldata_q[15:0]};
			3'd4: ld_val = {24'd0, ldata_q[7:0]};
			3'd5: ld_val = {16'd0, ldata_q[15:0]};
			default: ld_val = ldata_q;
		endcase
	end

	// memory address and byte for the current cycle
	logic [AW-1:0] maddr;
	logic [7:0] mwdata;
	always_comb begin
		if (op_q == rv32_pkg::OP_EXEC && !cmd.fetch) begin
			maddr = maddr_q + AW'(cnt_q);
			mwdata = b_q[8*cnt_q[1:0] +: 8];
		end else if (cmd.fetch) begin
			maddr = pc_q + AW'(cnt_q);
			mwdata = wbyte_q;
		end else begin
			maddr = baddr_q;
			mwdata = wbyte_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) mem[maddr] <= mwdata;
		if (cmd.mem_rd) rdata_q <= mem[maddr];
	end

	assign stat.op = rv32_pkg::op_t'(op_q);
	assign stat.is_load = isld_q;
	assign stat.is_store = isst_q;
	assign stat.nbytes = (f3_q[1:0] == 2'd0) ? 3'd1 : (f3_q[1:0] == 2'd1) ? 3'd2 : 3'd4;
	assign stat.cnt = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rcnt_q <= '0;
			pc_q <= '0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cnt_q != 3'd7 && cmd.cnt_inc) cnt_q <= cnt_q + 3'd1;
			// byte captures use rcnt_q, the counter value from the cycle before, when the read was issued
			rcnt_q <= cnt_q;
			if (cmd.restart) begin
				for (int i = 0; i < 32; i++) rf_q[i] <= '0;
				pc_q <= AW'(entry_q);
			end
			if (cmd.fetch && cnt_q != 3'd0) inst_q[8*rcnt_q[1:0] +: 8] <= rdata_q;
			if (op_q == rv32_pkg::OP_EXEC && !cmd.fetch && isld_q && !cmd.decode
				&& cnt_q != 3'd0 && !cmd.commit)
				ldata_q[8*rcnt_q[1:0] +: 8] <= rdata_q;
			if (cmd.decode) begin
				pc_q <= next32[AW-1:0];
				ldata_q <= '0;
				unique case (opc)
					rv32_pkg::OPC_BRANCH: if (take) pc_q <= AW'(pc32 + imm_b);
					rv32_pkg::OPC_JAL: pc_q <= AW'(pc32 + imm_j);
					rv32_pkg::OPC_JALR:
						if (f3 == 3'd0) pc_q <= AW'((ra + imm_i) & ~32'd1);
					default: ;
				endcase
			end
			if (cmd.commit && wen_q && rd_q != 5'd0)
				rf_q[rd_q] <= isld_q ? ld_val : res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q <= in_op;
			baddr_q <= AW'(in_addr);
			wbyte_q <= in_byte;
			isld_q <= 1'b0;
			isst_q <= 1'b0;
			wen_q <= 1'b0;
			status_q <= rv32_pkg::ST_CONT;
			cv_q <= 1'b0;
			co_q <= '0;
			rb_q <= '0;
		end
		if (cmd.mem_rd && op_q == rv32_pkg::OP_READ) rb_q <= mem[maddr];
		if (cmd.decode) begin
			maddr_q <= AW'(ra + ((opc == rv32_pkg::OPC_STORE) ? imm_s : imm_i));
			b_q <= rb;
			f3_q <= f3;
			rd_q <= inst_q[11:7];
			isld_q <= (opc == rv32_pkg::OPC_LOAD) && (f3 != 3'd3) && (f3 < 3'd6);
			isst_q <= (opc == rv32_pkg::OPC_STORE) && (f3 <= 3'd2);
			wen_q <= 1'b0;
			res_q <= alu;
			unique case (opc)
				rv32_pkg::OPC_OP: wen_q <= 1'b1;
				rv32_pkg::OPC_OPIMM: wen_q <= alu_ok;
				rv32_pkg::OPC_AUIPC: begin
					wen_q <= 1'b1;
					res_q <= pc32 + imm_u;
				end
				rv32_pkg::OPC_LUI: begin
					wen_q <= 1'b1;
					res_q <= imm_u;
				end
				rv32_pkg::OPC_LOAD: wen_q <= (f3 != 3'd3) && (f3 < 3'd6);
				rv32_pkg::OPC_JAL: begin
					wen_q <= 1'b1;
					res_q <= next32;
				end
				rv32_pkg::OPC_JALR: begin
					wen_q <= (f3 == 3'd0);
					res_q <= next32;
				end
				rv32_pkg::OPC_SYSTEM: begin
					if (rf_q[17] == 32'd1) begin
						cv_q <= 1'b1;
						co_q <= rf_q[10][7:0];
					end else status_q <= rv32_pkg::ST_HALT;
				end
				rv32_pkg::OPC_STORE, rv32_pkg::OPC_BRANCH, rv32_pkg::OPC_FENCE: ;
				default: status_q <= rv32_pkg::ST_BADOP;
			endcase
		end
	end

	assign status = status_q;
	assign char_valid = cv_q;
	assign char_out = co_q;
	assign read_byte = rb_q;
	assign pc_after = 16'(pc_q);

endmodule

FILE: hw/rtl/rv32i_instruction_step.sv
// one item at a time, a result per item held until taken
// write, read and restart: the fetch state, then the result is valid
// execute: fetch, execute, memory and writeback states, then the result;
// the single byte port of the memory moves one byte per cycle
// arst_n clears registers, pc and entry address; memory contents are undefined
module rv32i_instruction_step #(
	parameter int MEM_BYTES = 65536
) (
	input logic clk,
	input logic arst_n,
	rv32_in_if.sink in_ch,
	rv32_out_if.source out_ch,
	rv32_cfg_if.sink cfg
);

	rv32_pkg::cmd_t cmd;
	rv32_pkg::status_t stat;
	logic [15:0] entry_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) entry_q <= '0;
		else if (cfg.valid) entry_q <= cfg.data;
	end

	rv32_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.stat(stat),
		.cmd(cmd)
	);

	rv32_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.in_op(in_ch.op),
		.in_addr(in_ch.byte_address),
		.in_byte(in_ch.write_byte),
		.entry_q(entry_q),
		.status(out_ch.status),
		.char_valid(out_ch.char_valid),
		.char_out(out_ch.char_out),
		.read_byte(out_ch.read_byte),
		.pc_after(out_ch.pc_after)
	);

endmodule
